// ----- rtl/polynomial_real_root_finder_defines.svh -----
// Assertion helpers used by the RTL controller.
`ifndef POLYNOMIAL_REAL_ROOT_FINDER_DEFINES_SVH
`define POLYNOMIAL_REAL_ROOT_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PR_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pr assertion failed");

// Next-cycle implication, disabled during reset.
`define PR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pr assertion failed");

`endif

// ----- rtl/pr_pkg.sv -----
package pr_pkg;

  localparam int MAX_DEGREE     = 16;
  localparam int MAX_ITERATIONS = 50;
  localparam int FRAC_BITS      = 16;
  localparam int NUM_STARTS     = 11;

  localparam int Q_W    = 32;
  localparam int ACC_W  = 48;
  localparam int CFG_W  = 17;
  localparam int DEG_W  = 5;
  localparam int ADDR_W = $clog2(MAX_DEGREE + 1);
  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int SIDX_W = $clog2(NUM_STARTS);
  localparam int DVD_W  = ACC_W + FRAC_BITS;
  localparam int BIT_W  = $clog2(DVD_W);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [Q_W-1:0]   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};

  // result status codes
  localparam logic [1:0] ST_ROOT    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_DEGREE = 2'd0;
  localparam logic [1:0] CFG_TOL    = 2'd1;
  localparam logic [1:0] CFG_FLOOR  = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LD_GUESS = 4'd1;
  localparam logic [3:0] OP_LD_VALUE = 4'd2;
  localparam logic [3:0] OP_MUL_LO   = 4'd3;
  localparam logic [3:0] OP_MUL_HI   = 4'd4;
  localparam logic [3:0] OP_CMB      = 4'd5;
  localparam logic [3:0] OP_ADD_S    = 4'd6;
  localparam logic [3:0] OP_ADD_V    = 4'd7;
  localparam logic [3:0] OP_DIV_INIT = 4'd8;
  localparam logic [3:0] OP_DIV_STEP = 4'd9;
  localparam logic [3:0] OP_DIV_DONE = 4'd10;
  localparam logic [3:0] OP_UPD      = 4'd11;
  localparam logic [3:0] OP_LD_TMP   = 4'd12;
  localparam logic [3:0] OP_DEF_MUL  = 4'd13;
  localparam logic [3:0] OP_DEF_ADD  = 4'd14;

  typedef struct packed {
    logic [3:0]        op;
    logic              sel;          // 1: value, 0: slope
    logic [SIDX_W-1:0] start_idx;
    logic              emit;
    logic [1:0]        emit_status;
    logic [DEG_W-1:0]  emit_count;
  } pr_cmd_t;

  typedef struct packed {
    logic val_small;
    logic slope_bad;
    logic step_small;
  } pr_stat_t;

  typedef struct packed {
    logic              coeff_we;
    logic [ADDR_W-1:0] coeff_waddr;
    logic [ADDR_W-1:0] rd_addr;
    logic              work_we;
    logic [ADDR_W-1:0] work_waddr;
  } pr_mem_t;

  function automatic logic signed [Q_W-1:0] start_guess(input logic [SIDX_W-1:0] idx);
    logic signed [Q_W-1:0] k;
    case (idx)
      4'd1:    k = 32'sd1;
      4'd2:    k = -32'sd1;
      4'd3:    k = 32'sd2;
      4'd4:    k = -32'sd2;
      4'd5:    k = 32'sd3;
      4'd6:    k = -32'sd3;
      4'd7:    k = 32'sd5;
      4'd8:    k = -32'sd5;
      4'd9:    k = 32'sd10;
      4'd10:   k = -32'sd10;
      default: k = 32'sd0;
    endcase
    return k <<< FRAC_BITS;
  endfunction

endpackage

// ----- rtl/pr_ram.sv -----
module pr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pr_datapath.sv -----
module pr_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  pr_pkg::pr_cmd_t                  cmd,
  input  logic [pr_pkg::CFG_W-1:0]         tolerance,
  input  logic [pr_pkg::CFG_W-1:0]         slope_floor,
  input  logic [pr_pkg::Q_W-1:0]           work_rdata,
  input  logic [pr_pkg::Q_W-1:0]           coeff_rdata,
  output logic [pr_pkg::Q_W-1:0]           work_wdata,
  output pr_pkg::pr_stat_t                 stat,
  output logic                             result_strobe,
  output logic signed [pr_pkg::Q_W-1:0]    root_value,
  output logic [1:0]                       status,
  output logic [pr_pkg::DEG_W-1:0]         roots_count,
  output logic                             last_result
);
  import pr_pkg::*;

  logic signed [Q_W-1:0]   guess, step, tmp;
  logic signed [ACC_W-1:0] value, slope, mres;
  logic [2*Q_W-1:0]        prod, lo;
  logic [DVD_W-1:0]        dvd, quo;
  logic [ACC_W-1:0]        rem;

  logic [ACC_W-1:0] value_mag, slope_mag, op_a;
  logic [Q_W-1:0]   guess_mag, tmp_mag, step_mag, mul_a, q_sat;
  logic [2*Q_W-1:0] mul_p, r_sum;
  logic [ACC_W-1:0] r_sat;
  logic             op_neg;
  logic [ACC_W:0]   rem_sh;
  logic             ge;
  logic signed [ACC_W:0] pv, def_sum;
  logic signed [Q_W:0]   gdiff;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? $signed(~ACC_MAX) : $signed(ACC_MAX);
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W:0] s);
    if (s > $signed({{(ACC_W-Q_W+1){1'b0}}, Q_MAX})) begin
      return $signed(Q_MAX);
    end
    if (s < $signed({{(ACC_W-Q_W+1){1'b1}}, ~Q_MAX})) begin
      return $signed(~Q_MAX);
    end
    return s[Q_W-1:0];
  endfunction

  always_comb begin
    value_mag = value[ACC_W-1] ? (~value + 1'b1) : value;
    slope_mag = slope[ACC_W-1] ? (~slope + 1'b1) : slope;
    guess_mag = guess[Q_W-1] ? (~guess + 1'b1) : guess;
    tmp_mag   = tmp[Q_W-1] ? (~tmp + 1'b1) : tmp;
    step_mag  = step[Q_W-1] ? (~step + 1'b1) : step;
    op_a      = cmd.sel ? value_mag : slope_mag;
    op_neg    = (cmd.sel ? value[ACC_W-1] : slope[ACC_W-1]) ^ guess[Q_W-1];

    case (cmd.op)
      OP_MUL_LO:  mul_a = op_a[Q_W-1:0];
      OP_MUL_HI:  mul_a = Q_W'(op_a[ACC_W-1:Q_W]);
      default:    mul_a = tmp_mag;
    endcase
    mul_p = mul_a * guess_mag;

    // prod holds the high partial product here
    r_sum = (prod << FRAC_BITS) + (lo >> FRAC_BITS);
    r_sat = (r_sum > (2*Q_W)'(ACC_MAX)) ? ACC_MAX : r_sum[ACC_W-1:0];

    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = rem_sh >= {1'b0, slope_mag};

    q_sat = (quo > DVD_W'(Q_MAX)) ? Q_MAX : quo[Q_W-1:0];
    gdiff = {guess[Q_W-1], guess} - {step[Q_W-1], step};

    pv = (tmp[Q_W-1] ^ guess[Q_W-1])
         ? -$signed({1'b0, prod[FRAC_BITS +: ACC_W]})
         :  $signed({1'b0, prod[FRAC_BITS +: ACC_W]});
    def_sum = (ACC_W+1)'($signed(work_rdata)) + pv;
  end

  assign work_wdata      = (cmd.op == OP_DEF_ADD) ? tmp : coeff_rdata;
  assign stat.val_small  = value_mag < ACC_W'(tolerance);
  assign stat.slope_bad  = (slope == '0) || (slope_mag < ACC_W'(slope_floor));
  assign stat.step_small = step_mag < Q_W'(tolerance);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LD_GUESS: guess <= start_guess(cmd.start_idx);
      OP_LD_VALUE: begin
        value <= ACC_W'($signed(work_rdata));
        slope <= '0;
      end
      OP_MUL_LO:   prod <= mul_p;
      OP_MUL_HI: begin
        lo   <= prod;
        prod <= mul_p;
      end
      OP_CMB:      mres <= op_neg ? -$signed(r_sat) : $signed(r_sat);
      OP_ADD_S:    slope <= sat_acc((ACC_W+1)'(mres) + (ACC_W+1)'(value));
      OP_ADD_V:    value <= sat_acc((ACC_W+1)'(mres) + (ACC_W+1)'($signed(work_rdata)));
      OP_DIV_INIT: begin
        dvd <= {value_mag, FRAC_BITS'(0)};
        rem <= '0;
        quo <= '0;
      end
      OP_DIV_STEP: begin
        rem <= ge ? ACC_W'(rem_sh - {1'b0, slope_mag}) : rem_sh[ACC_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        dvd <= dvd << 1;
      end
      OP_DIV_DONE: step <= (value[ACC_W-1] ^ slope[ACC_W-1]) ? -$signed(q_sat) : $signed(q_sat);
      OP_UPD:      guess <= sat_q((ACC_W+1)'(gdiff));
      OP_LD_TMP:   tmp <= work_rdata;
      OP_DEF_MUL:  prod <= mul_p;
      OP_DEF_ADD:  tmp <= sat_q(def_sum);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      root_value  <= (cmd.emit_status == ST_ROOT) ? guess : '0;
      status      <= cmd.emit_status;
      roots_count <= cmd.emit_count;
      last_result <= cmd.emit_status != ST_ROOT;
    end
  end

endmodule

// ----- rtl/pr_controller.sv -----
`include "polynomial_real_root_finder_defines.svh"

module pr_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         last_coeff,
  input  logic [pr_pkg::DEG_W-1:0]     poly_degree,
  input  logic [pr_pkg::CFG_W-1:0]     tolerance,
  input  pr_pkg::pr_stat_t             stat,
  output logic                         busy,
  output pr_pkg::pr_cmd_t              cmd,
  output pr_pkg::pr_mem_t              mem
);
  import pr_pkg::*;

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_COPY_RD    = 5'd1;
  localparam logic [4:0] S_COPY_WR    = 5'd2;
  localparam logic [4:0] S_NEW_DEG    = 5'd3;
  localparam logic [4:0] S_START      = 5'd4;
  localparam logic [4:0] S_EVAL_INIT  = 5'd5;
  localparam logic [4:0] S_EVAL_LD0   = 5'd6;
  localparam logic [4:0] S_S_LO       = 5'd7;
  localparam logic [4:0] S_S_HI       = 5'd8;
  localparam logic [4:0] S_S_CMB      = 5'd9;
  localparam logic [4:0] S_S_ADD      = 5'd10;
  localparam logic [4:0] S_V_LO       = 5'd11;
  localparam logic [4:0] S_V_HI       = 5'd12;
  localparam logic [4:0] S_V_CMB      = 5'd13;
  localparam logic [4:0] S_V_ADD      = 5'd14;
  localparam logic [4:0] S_CHECK      = 5'd15;
  localparam logic [4:0] S_DIV_INIT   = 5'd16;
  localparam logic [4:0] S_DIV_STEP   = 5'd17;
  localparam logic [4:0] S_DIV_DONE   = 5'd18;
  localparam logic [4:0] S_UPD        = 5'd19;
  localparam logic [4:0] S_NEXT_START = 5'd20;
  localparam logic [4:0] S_ACCEPT     = 5'd21;
  localparam logic [4:0] S_DEF_INIT   = 5'd22;
  localparam logic [4:0] S_DEF_LD0    = 5'd23;
  localparam logic [4:0] S_DEF_MUL    = 5'd24;
  localparam logic [4:0] S_DEF_ADD    = 5'd25;

  logic [4:0]        state, state_next;
  logic [DEG_W-1:0]  load_count, load_count_next;
  logic [DEG_W-1:0]  rem_deg, rem_deg_next;
  logic [DEG_W-1:0]  roots, roots_next;
  logic [SIDX_W-1:0] sidx, sidx_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [BIT_W-1:0]  bit_cnt, bit_cnt_next;
  logic              accept, invalid;

  assign busy    = state != S_IDLE;
  assign accept  = start && !busy;
  assign invalid = (poly_degree == '0) || (poly_degree > DEG_W'(MAX_DEGREE))
                   || (tolerance == '0);

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    rem_deg_next    = rem_deg;
    roots_next      = roots;
    sidx_next       = sidx;
    iter_next       = iter;
    idx_next        = idx;
    bit_cnt_next    = bit_cnt;
    cmd             = '0;
    cmd.op          = OP_NONE;
    cmd.start_idx   = sidx;
    mem             = '0;
    mem.rd_addr     = idx;
    mem.coeff_waddr = load_count[ADDR_W-1:0];
    mem.work_waddr  = idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (load_count <= DEG_W'(MAX_DEGREE)) begin
            mem.coeff_we    = 1'b1;
            load_count_next = load_count + 1'b1;
          end
          if (last_coeff) begin
            load_count_next = '0;
            if (invalid) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_INVALID;
            end else begin
              idx_next   = '0;
              state_next = S_COPY_RD;
            end
          end
        end
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        mem.work_we = 1'b1;
        if (DEG_W'(idx) == poly_degree) begin
          rem_deg_next = poly_degree;
          roots_next   = '0;
          state_next   = S_NEW_DEG;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_NEW_DEG: begin
        if (rem_deg == '0) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_DONE;
          cmd.emit_count  = roots;
          state_next      = S_IDLE;
        end else begin
          sidx_next  = '0;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.op     = OP_LD_GUESS;
        iter_next  = '0;
        idx_next   = '0;
        state_next = S_EVAL_INIT;
      end
      S_EVAL_INIT: state_next = S_EVAL_LD0;
      S_EVAL_LD0: begin
        cmd.op     = OP_LD_VALUE;
        idx_next   = ADDR_W'(1);
        state_next = S_S_LO;
      end
      S_S_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_S_HI;
      end
      S_S_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_S_CMB;
      end
      S_S_CMB: begin
        cmd.op     = OP_CMB;
        state_next = S_S_ADD;
      end
      S_S_ADD: begin
        cmd.op     = OP_ADD_S;
        state_next = S_V_LO;
      end
      S_V_LO: begin
        cmd.op     = OP_MUL_LO;
        cmd.sel    = 1'b1;
        state_next = S_V_HI;
      end
      S_V_HI: begin
        cmd.op     = OP_MUL_HI;
        cmd.sel    = 1'b1;
        state_next = S_V_CMB;
      end
      S_V_CMB: begin
        cmd.op     = OP_CMB;
        cmd.sel    = 1'b1;
        state_next = S_V_ADD;
      end
      S_V_ADD: begin
        cmd.op  = OP_ADD_V;
        cmd.sel = 1'b1;
        if (DEG_W'(idx) == rem_deg) begin
          state_next = S_CHECK;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_S_LO;
        end
      end
      S_CHECK: begin
        if (stat.val_small) begin
          state_next = S_ACCEPT;
        end else if (stat.slope_bad) begin
          state_next = S_NEXT_START;
        end else begin
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op       = OP_DIV_INIT;
        bit_cnt_next = '0;
        state_next   = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        if (bit_cnt == BIT_W'(DVD_W - 1)) begin
          state_next = S_DIV_DONE;
        end else begin
          bit_cnt_next = bit_cnt + 1'b1;
        end
      end
      S_DIV_DONE: begin
        cmd.op     = OP_DIV_DONE;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op = OP_UPD;
        if (stat.step_small) begin
          state_next = S_ACCEPT;
        end else if (iter == ITER_W'(MAX_ITERATIONS - 1)) begin
          state_next = S_NEXT_START;
        end else begin
          iter_next  = iter + 1'b1;
          idx_next   = '0;
          state_next = S_EVAL_INIT;
        end
      end
      S_NEXT_START: begin
        if (sidx == SIDX_W'(NUM_STARTS - 1)) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_DONE;
          cmd.emit_count  = roots;
          state_next      = S_IDLE;
        end else begin
          sidx_next  = sidx + 1'b1;
          state_next = S_START;
        end
      end
      S_ACCEPT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_ROOT;
        cmd.emit_count  = roots + 1'b1;
        roots_next      = roots + 1'b1;
        idx_next        = '0;
        state_next      = S_DEF_INIT;
      end
      S_DEF_INIT: state_next = S_DEF_LD0;
      S_DEF_LD0: begin
        cmd.op     = OP_LD_TMP;
        idx_next   = ADDR_W'(1);
        state_next = S_DEF_MUL;
      end
      S_DEF_MUL: begin
        cmd.op     = OP_DEF_MUL;
        state_next = S_DEF_ADD;
      end
      S_DEF_ADD: begin
        cmd.op         = OP_DEF_ADD;
        mem.work_we    = 1'b1;
        mem.work_waddr = idx - 1'b1;
        if (DEG_W'(idx) == rem_deg) begin
          rem_deg_next = rem_deg - 1'b1;
          state_next   = S_NEW_DEG;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DEF_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      rem_deg    <= '0;
      roots      <= '0;
      sidx       <= '0;
      iter       <= '0;
      idx        <= '0;
      bit_cnt    <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      rem_deg    <= rem_deg_next;
      roots      <= roots_next;
      sidx       <= sidx_next;
      iter       <= iter_next;
      idx        <= idx_next;
      bit_cnt    <= bit_cnt_next;
    end
  end

  `PR_ASSERT_NEXT(a_final_to_idle, cmd.emit && (cmd.emit_status != ST_ROOT), state == S_IDLE)
  `PR_ASSERT_NOW(a_accept_degree, state == S_ACCEPT, rem_deg != '0)
  `PR_ASSERT_NOW(a_work_addr, mem.work_we, mem.work_waddr <= ADDR_W'(MAX_DEGREE))
  `PR_ASSERT_NEXT(a_root_count, state == S_ACCEPT, roots == $past(roots) + 1'b1)

endmodule

// ----- rtl/polynomial_real_root_finder.sv -----
// Polynomial real-root finder, Newton steps with deflation, signed Q16.16.
// Requests: pulse start with coefficient/last_coeff while busy is low; one
//   coefficient per request, highest power first. last_coeff marks the final
//   one and launches the search; busy stays high until the search ends.
// Config: cfg_write/cfg_index/cfg_data, written while idle. 0 poly_degree,
//   1 tolerance, 2 slope_floor.
// Results: result_strobe is high for one cycle per result; one item per root
//   (status 0), then a final item (status 1, last_result 1) with the count.
//   Bad arguments give a single status 2 item in the cycle after the request.
// Operation: the store is first copied to the working copy. A Newton step
//   evaluates value and slope by multiply-accumulates through the shared
//   32x32 multiplier (low, high, combine and add steps each), then runs a
//   bit-serial divider. Deflation follows each accepted root.
// Reset: registers go to degree 2, tolerance 66, slope floor 1; the store
//   content stays undefined until loaded. Results cannot be stalled.
module polynomial_real_root_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [pr_pkg::Q_W-1:0] coefficient,
  input  logic                          last_coeff,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [pr_pkg::CFG_W-1:0]      cfg_data,
  output logic                          result_strobe,
  output logic signed [pr_pkg::Q_W-1:0] root_value,
  output logic [1:0]                    status,
  output logic [pr_pkg::DEG_W-1:0]      roots_count,
  output logic                          last_result
);
  import pr_pkg::*;

  logic [DEG_W-1:0] poly_degree;
  logic [CFG_W-1:0] tolerance;
  logic [CFG_W-1:0] slope_floor;

  pr_cmd_t  cmd;
  pr_stat_t stat;
  pr_mem_t  mem;

  logic [Q_W-1:0] coeff_rdata, work_rdata, work_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_degree <= DEG_W'(2);
      tolerance   <= CFG_W'(66);
      slope_floor <= CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEGREE: poly_degree <= cfg_data[DEG_W-1:0];
        CFG_TOL:    tolerance   <= cfg_data;
        CFG_FLOOR:  slope_floor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // loaded coefficients, kept across runs
  pr_ram #(.WIDTH(Q_W), .DEPTH(MAX_DEGREE + 1)) u_coeff_ram (
    .clk   (clk),
    .we    (mem.coeff_we),
    .waddr (mem.coeff_waddr),
    .wdata (coefficient),
    .raddr (mem.rd_addr),
    .rdata (coeff_rdata)
  );

  // working copy, deflated in place
  pr_ram #(.WIDTH(Q_W), .DEPTH(MAX_DEGREE + 1)) u_work_ram (
    .clk   (clk),
    .we    (mem.work_we),
    .waddr (mem.work_waddr),
    .wdata (work_wdata),
    .raddr (mem.rd_addr),
    .rdata (work_rdata)
  );

  pr_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_coeff  (last_coeff),
    .poly_degree (poly_degree),
    .tolerance   (tolerance),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd),
    .mem         (mem)
  );

  pr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .tolerance     (tolerance),
    .slope_floor   (slope_floor),
    .work_rdata    (work_rdata),
    .coeff_rdata   (coeff_rdata),
    .work_wdata    (work_wdata),
    .stat          (stat),
    .result_strobe (result_strobe),
    .root_value    (root_value),
    .status        (status),
    .roots_count   (roots_count),
    .last_result   (last_result)
  );

endmodule

// ----- dv/tb_polynomial_real_root_finder.sv -----
module tb_polynomial_real_root_finder;
  import pr_pkg::*;

  // one result item as seen on the result ports
  typedef struct {
    logic signed [Q_W-1:0] root;
    logic [1:0]            st;
    logic [DEG_W-1:0]      cnt;
    logic                  last;
  } root_item_t;

  // Scoreboard: owns a bit-exact model of the root search and the queue of
  // result items it predicts; results are checked in order against it.
  class root_scoreboard;
    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint W_HI   = 64'sh7FFF_FFFF;
    localparam longint W_LO   = -W_HI - 1;

    longint     coeffs [MAX_DEGREE+1];
    int         fill_level;
    int         degree_reg;
    longint     tol_reg;
    longint     floor_reg;
    root_item_t pending_roots[$];
    int         mismatches;
    int         checked;
    int         roots_seen;

    function new();
      degree_reg = 2;
      tol_reg    = 66;
      floor_reg  = 1;
      fill_level = 0;
      mismatches = 0;
      checked    = 0;
      roots_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_DEGREE) degree_reg = data[DEG_W-1:0];
      else if (idx == CFG_TOL) tol_reg = data;
      else if (idx == CFG_FLOOR) floor_reg = data;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // accumulator times guess, Q-scaled, saturated to 48 bits
    function longint acc_mul(longint a, longint b);
      longint unsigned ma, mb, lo, hi, r;
      ma = mag(a);
      mb = mag(b);
      lo = (ma & 64'hFFFF_FFFF) * mb;
      hi = (ma >> 32) * mb;
      if (hi > (longint'(ACC_HI) >> (32 - FRAC_BITS))) r = ACC_HI;
      else r = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
      if (r > ACC_HI) r = ACC_HI;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Newton step value/slope, restoring division with FRAC_BITS extra bits
    function longint step_div(longint f, longint d);
      longint unsigned mf, md, q, r;
      mf = mag(f);
      md = mag(d);
      q = mf / md;
      r = mf % md;
      if (q > (W_HI >> FRAC_BITS)) begin
        q = W_HI;
      end else begin
        for (int k = 0; k < FRAC_BITS; k++) begin
          r = r << 1;
          q = q << 1;
          if (r >= md) begin
            r = r - md;
            q = q | 1;
          end
        end
        if (q > W_HI) q = W_HI;
      end
      return ((f < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function void push_item(longint root, logic [1:0] st, int cnt, logic last);
      root_item_t it;
      it.root = root[Q_W-1:0];
      it.st   = st;
      it.cnt  = cnt[DEG_W-1:0];
      it.last = last;
      pending_roots.push_back(it);
    endfunction

    function void search_roots();
      longint work [MAX_DEGREE+1];
      longint g, val, slp, stp, root, tmp, nxt, prod;
      longint unsigned pm;
      int     left, found;
      bit     ok;
      if (degree_reg == 0 || degree_reg > MAX_DEGREE || tol_reg == 0) begin
        push_item(0, ST_INVALID, 0, 1'b1);
        return;
      end
      for (int i = 0; i <= degree_reg; i++) work[i] = coeffs[i];
      left  = degree_reg;
      found = 0;
      while (left >= 1) begin
        ok   = 0;
        root = 0;
        for (int s = 0; s < NUM_STARTS && !ok; s++) begin
          g = longint'(start_guess(s[SIDX_W-1:0]));
          for (int it = 0; it < MAX_ITERATIONS; it++) begin
            val = work[0];
            slp = 0;
            for (int i = 1; i <= left; i++) begin
              slp = clamp(acc_mul(slp, g) + val, ACC_LO, ACC_HI);
              val = clamp(acc_mul(val, g) + work[i], ACC_LO, ACC_HI);
            end
            if (mag(val) < tol_reg) begin
              root = g;
              ok = 1;
              break;
            end
            // exactly zero slope always gives up, floor or not
            if (slp == 0 || mag(slp) < floor_reg) break;
            stp = step_div(val, slp);
            g = clamp(g - stp, W_LO, W_HI);
            if (mag(stp) < tol_reg) begin
              root = g;
              ok = 1;
              break;
            end
          end
        end
        if (!ok) break;
        found++;
        push_item(root, ST_ROOT, found, 1'b0);
        // synthetic division by (x - root), exact product then shift
        tmp = work[0];
        for (int i = 1; i <= left; i++) begin
          pm = (mag(tmp) * mag(root)) >> FRAC_BITS;
          prod = ((tmp < 0) != (root < 0)) ? -longint'(pm) : longint'(pm);
          nxt = clamp(work[i] + prod, W_LO, W_HI);
          work[i-1] = tmp;
          tmp = nxt;
        end
        left--;
      end
      push_item(0, ST_DONE, found, 1'b1);
    endfunction

    // accepted coefficient request
    function void note_request(logic signed [Q_W-1:0] c, logic last);
      // store full: extra coefficients are dropped
      if (fill_level <= MAX_DEGREE) begin
        coeffs[fill_level] = longint'(c);
        fill_level++;
      end
      if (last) begin
        fill_level = 0;
        search_roots();
      end
    endfunction

    function void check_result(root_item_t got);
      root_item_t want;
      checked++;
      if (got.st == ST_ROOT) roots_seen++;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: root=%h st=%0d cnt=%0d last=%0d",
                   got.root, got.st, got.cnt, got.last);
        return;
      end
      want = pending_roots.pop_front();
      if (got.root !== want.root || got.st !== want.st ||
          got.cnt !== want.cnt || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp root=%h st=%0d cnt=%0d last=%0d, got root=%h st=%0d cnt=%0d last=%0d",
                   want.root, want.st, want.cnt, want.last,
                   got.root, got.st, got.cnt, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [Q_W-1:0] coefficient = '0;
  logic                  last_coeff = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = CFG_DEGREE;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  result_strobe;
  logic signed [Q_W-1:0] root_value;
  logic [1:0]            status;
  logic [DEG_W-1:0]      roots_count;
  logic                  last_result;

  polynomial_real_root_finder u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coefficient(coefficient), .last_coeff(last_coeff),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .root_value(root_value), .status(status),
    .roots_count(roots_count), .last_result(last_result)
  );

  always #1 clk = ~clk;

  root_scoreboard sb = new();
  int     req_total;
  int     search_total;
  int     burst_left;
  longint cycles;

  // results cannot be held off: grab every strobe at the rising edge
  always @(posedge clk) begin
    root_item_t r;
    if (!rst && result_strobe) begin
      r.root = root_value;
      r.st   = status;
      r.cnt  = roots_count;
      r.last = last_result;
      sb.check_result(r);
    end
  end

  // watchdog, sized well past the slowest plausible search mix
  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd200_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_polynomial_real_root_finder: FAIL");
      $finish;
    end
  end

  // one coefficient request; sender idles between bursts of random length
  task automatic send_coeff(input logic signed [Q_W-1:0] c, input logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start       = 1'b1;
    coefficient = c;
    last_coeff  = last;
    do @(posedge clk); while (busy);
    sb.note_request(c, last);
    req_total++;
    if (last) search_total++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // register writes only once the block has drained
  task automatic wait_idle();
    while (sb.pending_roots.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_regs(input int deg, input int tol, input int flr);
    wait_idle();
    write_reg(CFG_DEGREE, deg[CFG_W-1:0]);
    write_reg(CFG_TOL, tol[CFG_W-1:0]);
    write_reg(CFG_FLOOR, flr[CFG_W-1:0]);
  endtask

  // send a coefficient list, last one marked
  task automatic send_poly(input longint cq[$]);
    foreach (cq[i]) send_coeff(cq[i][Q_W-1:0], i == cq.size() - 1);
  endtask

  // lead * prod (x - r_k) in Q16.16, roots on a half-integer grid
  function automatic void build_poly(input int deg, output longint cq[$]);
    longint lead, r, nq[$];
    lead = longint'($urandom_range(1, 3)) << FRAC_BITS;
    if ($urandom_range(0, 1)) lead = -lead;
    cq = {lead};
    for (int k = 0; k < deg; k++) begin
      r = (longint'($urandom_range(0, 24)) - 12) <<< (FRAC_BITS - 1);
      nq = {cq[0]};
      for (int i = 1; i < cq.size(); i++) nq.push_back(cq[i] - ((r * cq[i-1]) >>> FRAC_BITS));
      nq.push_back(-((r * cq[cq.size()-1]) >>> FRAC_BITS));
      cq = nq;
    end
    foreach (cq[i]) begin
      if (cq[i] > 64'sh7FFF_FFFF) cq[i] = 64'sh7FFF_FFFF;
      if (cq[i] < -64'sh8000_0000) cq[i] = -64'sh8000_0000;
    end
  endfunction

  function automatic int pick_tol();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 65536;
      2: return $urandom_range(1, 65536);
      default: return 66;
    endcase
  endfunction

  function automatic int pick_floor();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(0, 65536);
      default: return 1;
    endcase
  endfunction

  initial begin
    longint cq[$];
    int     deg, kind;
    req_total    = 0;
    search_total = 0;
    burst_left   = 0;
    cycles       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // x^16 - 1 with one extra coefficient: fills every store entry and
    // exercises the full-store drop
    set_regs(MAX_DEGREE, 66, 1);
    cq = {};
    cq.push_back(longint'(1) << FRAC_BITS);
    repeat (15) cq.push_back(0);
    cq.push_back(-(longint'(1) << FRAC_BITS));
    cq.push_back(longint'(32'sh1234_5678));
    send_poly(cq);

    // degree zero, degree above max, zero tolerance: invalid
    set_regs(0, 66, 1);
    send_coeff(32'sh0001_0000, 1'b1);
    set_regs(31, 66, 1);
    send_coeff(32'sh0001_0000, 1'b1);
    set_regs(2, 0, 1);
    send_coeff(32'sh0001_0000, 1'b1);
    // x^2 + 1 with floor 0: zero slope at guess 0 still gives up
    set_regs(2, 66, 0);
    send_poly({64'sh1_0000, 0, 64'sh1_0000});
    // coefficient extremes, loose tolerance and high floor
    set_regs(1, 65536, 65536);
    send_poly({64'sh7FFF_FFFF, -64'sh8000_0000});
    // degree 3 with only two loads: search reuses older entries
    set_regs(3, 66, 1);
    send_poly({-64'sh8000_0000, 64'sh7FFF_FFFF});

    // random part: mostly well-formed polynomials, some noise
    while (req_total < 420) begin
      kind = $urandom_range(0, 99);
      deg  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      if (kind < 4) begin
        set_regs(($urandom_range(0, 1) ? 0 : $urandom_range(17, 31)),
                 ($urandom_range(0, 1) ? 0 : pick_tol()), pick_floor());
        send_coeff($urandom, 1'b1);
      end else if (kind < 80) begin
        set_regs(deg, pick_tol(), pick_floor());
        build_poly(deg, cq);
        send_poly(cq);
      end else begin
        // noise: random 32-bit or small words, low degree to bound failing searches
        deg = $urandom_range(1, 2);
        set_regs(deg, pick_tol(), pick_floor());
        cq = {};
        for (int i = 0; i <= deg + $urandom_range(0, 1); i++)
          cq.push_back($urandom_range(0, 1) ? longint'(signed'($urandom))
                                            : longint'($urandom_range(0, 1 << 19)) - (1 << 18));
        send_poly(cq);
      end
    end

    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d coefficient requests, %0d searches, %0d results (%0d roots)",
             req_total, search_total, sb.checked, sb.roots_seen);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_roots.size() == 0) begin
      $display("tb_polynomial_real_root_finder: PASS");
    end else begin
      $display("tb_polynomial_real_root_finder: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pr_pkg.sv
rtl/pr_ram.sv
rtl/pr_datapath.sv
rtl/pr_controller.sv
rtl/polynomial_real_root_finder.sv
dv/tb_polynomial_real_root_finder.sv
